// ===== hw/rtl/gtg_pkg.sv =====
package gtg_pkg;

    localparam int MAX_DIM   = 4096;
    localparam int DIM_W     = 13;
    localparam int POS_W     = 12;
    localparam int IDX_W     = 24;
    localparam int PROD_W    = 2 * DIM_W;
    localparam int SUM_W     = DIM_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int STEP_W    = $clog2(DIM_W);
    localparam int TDATA_W   = 56;
    localparam int IN_TDATA_W = 24;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIM_W - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 3'd0,
        REG_IMAGE_HEIGHT = 3'd1,
        REG_GRID_COLUMNS = 3'd2,
        REG_GRID_ROWS    = 3'd3,
        REG_ORIGIN_X     = 3'd4,
        REG_ORIGIN_Y     = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_LOAD,
        SEQ_DIV
    } seq_state_t;

    typedef enum logic [1:0] {
        OP_WIDTH,
        OP_HEIGHT,
        OP_ORIGIN_X,
        OP_ORIGIN_Y
    } seq_op_t;

    typedef struct packed {
        logic              ready;
        logic [DIM_W-1:0]  w;
        logic [DIM_W-1:0]  h;
        logic [DIM_W-1:0]  cols;
        logic [DIM_W-1:0]  rows;
        logic [DIM_W-1:0]  qw;
        logic [DIM_W-1:0]  rw;
        logic [DIM_W-1:0]  qh;
        logic [DIM_W-1:0]  rh;
        logic [POS_W-1:0]  oxm;
        logic [POS_W-1:0]  oym;
        logic [PROD_W-1:0] total;
    } geom_t;

    typedef struct packed {
        logic             ge;
        logic [DIM_W-1:0] rem;
    } div_trial_t;

    typedef struct packed {
        logic [DIM_W-1:0] rem;
        logic [IDX_W-1:0] dv;
        logic             range;
    } div_stage_t;

    typedef struct packed {
        logic [DIM_W-1:0] tw;
        logic [DIM_W-1:0] th;
        logic [POS_W-1:0] left;
        logic [POS_W-1:0] top;
        logic             range;
    } result_t;

    // One restoring division step: shift a dividend bit into the partial
    // remainder and subtract the divisor when it fits.
    function automatic div_trial_t div_trial(input logic [DIM_W-1:0] rem,
                                             input logic bit_in,
                                             input logic [DIM_W-1:0] divisor);
        logic [DIM_W:0] t;
        logic [DIM_W:0] d;
        div_trial_t     r;
        t     = {rem, bit_in};
        d     = t - {1'b0, divisor};
        r.ge  = (t >= {1'b0, divisor});
        r.rem = r.ge ? d[DIM_W-1:0] : t[DIM_W-1:0];
        return r;
    endfunction

endpackage

// ===== hw/rtl/grid_tile_geometry.sv =====
// Tile geometry for an image cut into a grid of rows by columns tiles.
// The slave stream takes a row-major tile index per word; the master stream
// returns that tile's width, height and wrapped top-left pixel, with tuser
// high when the index lies inside the grid and low (all data zero) otherwise.
// The configuration channel writes the image size, the grid size and the
// grid origin; leftover pixels go one each to the first columns and rows.
// After each configuration write a shared divider works out the tile shares
// and the wrapped origins: s_tready stays low while it runs.
// Once set up the block takes one index every cycle until a receiver stall
// fills the skid register. Each index is taken into an entry register and
// then passes one restoring divider stage per index bit (24), two stages
// of multiply and add, and the output register.
// When the receiver stalls, a skid register takes one further word, then
// the whole pipeline holds and s_tready falls; nothing is lost or repeated.
// Reset loads a 1 by 1 image with a single tile at the origin, so the block
// is ready to accept words as soon as reset is released.
module grid_tile_geometry (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [gtg_pkg::IN_TDATA_W-1:0]    s_tdata,   // [23:0] tile_index
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [12:0] width, [25:13] height, [37:26] left, [49:38] top, [55:50] zero.
    output logic [gtg_pkg::TDATA_W-1:0]       m_tdata,
    output logic                              m_tuser,   // [0] in_range
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gtg_pkg::DIM_W-1:0]         cfg_data
);
    import gtg_pkg::*;

    geom_t            geo;
    logic             adv;
    logic             s_accept;
    logic             m_accept;

    logic             ent_valid_reg;
    logic [IDX_W-1:0] ent_idx_reg;
    logic             ent_range_reg;

    logic             dv_valid;
    div_stage_t       dv_stage;

    logic [DIM_W-1:0]  col;
    logic [DIM_W-1:0]  row;
    logic              xlt;
    logic              ylt;
    logic [PROD_W-1:0] xprod;
    logic [PROD_W-1:0] yprod;

    logic              p1_valid_reg;
    logic              p1_range_reg;
    logic [PROD_W-1:0] p1_xprod_reg;
    logic [PROD_W-1:0] p1_yprod_reg;
    logic [DIM_W-1:0]  p1_xmin_reg;
    logic [DIM_W-1:0]  p1_ymin_reg;
    logic [DIM_W-1:0]  p1_tw_reg;
    logic [DIM_W-1:0]  p1_th_reg;

    logic              p2_valid_reg;
    logic              p2_range_reg;
    logic [SUM_W-1:0]  p2_xsum_reg;
    logic [SUM_W-1:0]  p2_ysum_reg;
    logic [DIM_W-1:0]  p2_tw_reg;
    logic [DIM_W-1:0]  p2_th_reg;

    logic [SUM_W-1:0]  xleft;
    logic [SUM_W-1:0]  ytop;
    logic              p_valid;
    result_t           p_res;

    logic              out_valid_reg;
    result_t           out_reg;
    logic              skid_valid_reg;
    result_t           skid_reg;

    gtg_setup u_setup (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geo       (geo)
    );

    assign adv      = !skid_valid_reg;
    assign s_tready = adv && geo.ready;
    assign s_accept = s_tvalid && s_tready;
    assign m_accept = out_valid_reg && m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ent_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            ent_valid_reg <= s_accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ent_idx_reg   <= s_tdata[IDX_W-1:0];
            ent_range_reg <= PROD_W'(s_tdata[IDX_W-1:0]) < geo.total;
        end
    end

    gtg_div_pipe u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (ent_valid_reg),
        .in_idx    (ent_idx_reg),
        .in_range  (ent_range_reg),
        .divisor   (geo.cols),
        .out_valid (dv_valid),
        .out_stage (dv_stage)
    );

    // An out-of-range row may be truncated here; its result is zeroed later.
    assign col   = dv_stage.rem;
    assign row   = dv_stage.dv[DIM_W-1:0];
    assign xlt   = col < geo.rw;
    assign ylt   = row < geo.rh;
    assign xprod = PROD_W'(col) * PROD_W'(geo.qw);
    assign yprod = PROD_W'(row) * PROD_W'(geo.qh);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            p1_valid_reg <= dv_valid;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_range_reg <= dv_stage.range;
            p1_xprod_reg <= xprod;
            p1_yprod_reg <= yprod;
            p1_xmin_reg  <= xlt ? col : geo.rw;
            p1_ymin_reg  <= ylt ? row : geo.rh;
            p1_tw_reg    <= geo.qw + DIM_W'(xlt);
            p1_th_reg    <= geo.qh + DIM_W'(ylt);

            p2_range_reg <= p1_range_reg;
            p2_xsum_reg  <= SUM_W'(geo.oxm) + p1_xprod_reg[SUM_W-1:0] + SUM_W'(p1_xmin_reg);
            p2_ysum_reg  <= SUM_W'(geo.oym) + p1_yprod_reg[SUM_W-1:0] + SUM_W'(p1_ymin_reg);
            p2_tw_reg    <= p1_tw_reg;
            p2_th_reg    <= p1_th_reg;
        end
    end

    // The sums stay below twice the image size, so one subtraction wraps them.
    assign xleft = (p2_xsum_reg >= SUM_W'(geo.w)) ? (p2_xsum_reg - SUM_W'(geo.w)) : p2_xsum_reg;
    assign ytop  = (p2_ysum_reg >= SUM_W'(geo.h)) ? (p2_ysum_reg - SUM_W'(geo.h)) : p2_ysum_reg;

    assign p_valid = p2_valid_reg && adv;

    always_comb
    begin
        p_res.range = p2_range_reg;
        p_res.tw    = p2_range_reg ? p2_tw_reg : '0;
        p_res.th    = p2_range_reg ? p2_th_reg : '0;
        p_res.left  = p2_range_reg ? xleft[POS_W-1:0] : '0;
        p_res.top   = p2_range_reg ? ytop[POS_W-1:0] : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (skid_valid_reg)
        begin
            if (m_accept)
            begin
                skid_valid_reg <= 1'b0;
            end
        end
        else if (p_valid)
        begin
            if (!out_valid_reg || m_accept)
            begin
                out_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
        else if (m_accept)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_accept)
            begin
                out_reg <= skid_reg;
            end
        end
        else if (p_valid)
        begin
            if (!out_valid_reg || m_accept)
            begin
                out_reg <= p_res;
            end
            else
            begin
                skid_reg <= p_res;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_reg.range;
    assign m_tdata  = {{(TDATA_W - 2 * DIM_W - 2 * POS_W){1'b0}},
                       out_reg.top, out_reg.left, out_reg.th, out_reg.tw};

`ifndef SYNTH
    a_zero_when_outside: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == '0)
        else $error("A tile outside the grid carries non-zero geometry.");

    a_skid_behind_output: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("Skid register holds a word while the output is empty.");

    a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(skid_valid_reg) |-> $past(out_valid_reg && !m_tready))
        else $error("Skid register filled without an output stall.");
`endif

endmodule

// ===== hw/rtl/gtg_setup.sv =====
module gtg_setup (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [gtg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [gtg_pkg::DIM_W-1:0]      cfg_data,
    output gtg_pkg::geom_t                 geo
);
    import gtg_pkg::*;

    logic [DIM_W-1:0] image_width_reg;
    logic [DIM_W-1:0] image_height_reg;
    logic [DIM_W-1:0] grid_columns_reg;
    logic [DIM_W-1:0] grid_rows_reg;
    logic [DIM_W-1:0] origin_x_reg;
    logic [DIM_W-1:0] origin_y_reg;

    logic [DIM_W-1:0] w_eff;
    logic [DIM_W-1:0] h_eff;
    logic [DIM_W-1:0] cols_eff;
    logic [DIM_W-1:0] rows_eff;

    seq_state_t        seq_state_reg;
    seq_state_t        seq_state_next;
    seq_op_t           op_reg;
    seq_op_t           op_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic [DIM_W-1:0]  rem_reg;
    logic [DIM_W-1:0]  rem_next;
    logic [DIM_W-1:0]  quo_reg;
    logic [DIM_W-1:0]  quo_next;
    logic              last_step;

    logic [DIM_W-1:0]  dividend;
    logic [DIM_W-1:0]  divisor;
    logic              neg;
    logic [DIM_W-1:0]  fold_full;
    div_trial_t        trial;

    logic [DIM_W-1:0]  qw_reg;
    logic [DIM_W-1:0]  rw_reg;
    logic [DIM_W-1:0]  qh_reg;
    logic [DIM_W-1:0]  rh_reg;
    logic [POS_W-1:0]  oxm_reg;
    logic [POS_W-1:0]  oym_reg;
    logic [PROD_W-1:0] total_reg;
    logic              cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= DIM_W'(1);
            image_height_reg <= DIM_W'(1);
            grid_columns_reg <= DIM_W'(1);
            grid_rows_reg    <= DIM_W'(1);
            origin_x_reg     <= '0;
            origin_y_reg     <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  image_width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: image_height_reg <= cfg_data;
                REG_GRID_COLUMNS: grid_columns_reg <= cfg_data;
                REG_GRID_ROWS:    grid_rows_reg    <= cfg_data;
                REG_ORIGIN_X:     origin_x_reg     <= cfg_data;
                REG_ORIGIN_Y:     origin_y_reg     <= cfg_data;
                default:          ;
            endcase
        end
    end

    assign w_eff = (image_width_reg == '0) ? DIM_W'(1) :
                   (image_width_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_width_reg;
    assign h_eff = (image_height_reg == '0) ? DIM_W'(1) :
                   (image_height_reg > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : image_height_reg;
    assign cols_eff = (grid_columns_reg != '0) ? grid_columns_reg : w_eff;
    assign rows_eff = (grid_rows_reg != '0) ? grid_rows_reg : h_eff;

    always_comb
    begin
        case (op_reg)
            OP_WIDTH:
            begin
                dividend = w_eff;
                divisor  = cols_eff;
                neg      = 1'b0;
            end
            OP_HEIGHT:
            begin
                dividend = h_eff;
                divisor  = rows_eff;
                neg      = 1'b0;
            end
            OP_ORIGIN_X:
            begin
                neg      = origin_x_reg[DIM_W-1];
                dividend = neg ? (~origin_x_reg + DIM_W'(1)) : origin_x_reg;
                divisor  = w_eff;
            end
            OP_ORIGIN_Y:
            begin
                neg      = origin_y_reg[DIM_W-1];
                dividend = neg ? (~origin_y_reg + DIM_W'(1)) : origin_y_reg;
                divisor  = h_eff;
            end
            default:
            begin
                dividend = w_eff;
                divisor  = cols_eff;
                neg      = 1'b0;
            end
        endcase
    end

    assign trial = div_trial(rem_reg, quo_reg[DIM_W-1], divisor);

    always_comb
    begin
        seq_state_next = seq_state_reg;
        op_next        = op_reg;
        step_next      = step_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        last_step      = 1'b0;
        case (seq_state_reg)
            SEQ_IDLE:
            begin
            end
            SEQ_LOAD:
            begin
                rem_next       = '0;
                quo_next       = dividend;
                step_next      = '0;
                seq_state_next = SEQ_DIV;
            end
            SEQ_DIV:
            begin
                rem_next  = trial.rem;
                quo_next  = {quo_reg[DIM_W-2:0], trial.ge};
                step_next = step_reg + STEP_W'(1);
                if (step_reg == LAST_STEP)
                begin
                    last_step = 1'b1;
                    step_next = '0;
                    if (op_reg == OP_ORIGIN_Y)
                    begin
                        seq_state_next = SEQ_IDLE;
                    end
                    else
                    begin
                        op_next        = seq_op_t'(op_reg + 2'd1);
                        seq_state_next = SEQ_LOAD;
                    end
                end
            end
            default:
            begin
                seq_state_next = SEQ_IDLE;
            end
        endcase
        if (cfg_write)
        begin
            seq_state_next = SEQ_LOAD;
            op_next        = OP_WIDTH;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_state_reg <= SEQ_IDLE;
            op_reg        <= OP_WIDTH;
            step_reg      <= '0;
        end
        else
        begin
            seq_state_reg <= seq_state_next;
            op_reg        <= op_next;
            step_reg      <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    // A negative offset leaves a remainder that is folded back into the image.
    assign fold_full = (neg && (rem_next != '0)) ? (divisor - rem_next) : rem_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qw_reg    <= DIM_W'(1);
            rw_reg    <= '0;
            qh_reg    <= DIM_W'(1);
            rh_reg    <= '0;
            oxm_reg   <= '0;
            oym_reg   <= '0;
            total_reg <= PROD_W'(1);
        end
        else
        begin
            total_reg <= PROD_W'(cols_eff) * PROD_W'(rows_eff);
            if (last_step)
            begin
                case (op_reg)
                    OP_WIDTH:
                    begin
                        qw_reg <= quo_next;
                        rw_reg <= rem_next;
                    end
                    OP_HEIGHT:
                    begin
                        qh_reg <= quo_next;
                        rh_reg <= rem_next;
                    end
                    OP_ORIGIN_X: oxm_reg <= fold_full[POS_W-1:0];
                    OP_ORIGIN_Y: oym_reg <= fold_full[POS_W-1:0];
                    default:     ;
                endcase
            end
        end
    end

    always_comb
    begin
        geo.ready = (seq_state_reg == SEQ_IDLE);
        geo.w     = w_eff;
        geo.h     = h_eff;
        geo.cols  = cols_eff;
        geo.rows  = rows_eff;
        geo.qw    = qw_reg;
        geo.rw    = rw_reg;
        geo.qh    = qh_reg;
        geo.rh    = rh_reg;
        geo.oxm   = oxm_reg;
        geo.oym   = oym_reg;
        geo.total = total_reg;
    end

`ifndef SYNTH
    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        seq_state_reg == SEQ_IDLE |-> rw_reg < cols_eff && rh_reg < rows_eff)
        else $error("Tile residue is not below the tile count.");

    a_origin_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        seq_state_reg == SEQ_IDLE |-> {1'b0, oxm_reg} < w_eff && {1'b0, oym_reg} < h_eff)
        else $error("Wrapped origin lies outside the image.");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        seq_state_reg == SEQ_DIV && step_reg == LAST_STEP |=> seq_state_reg != SEQ_DIV)
        else $error("Divider ran past its last step.");
`endif

endmodule

// ===== hw/rtl/gtg_div_pipe.sv =====
module gtg_div_pipe (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      adv,
    input  logic                      in_valid,
    input  logic [gtg_pkg::IDX_W-1:0] in_idx,
    input  logic                      in_range,
    input  logic [gtg_pkg::DIM_W-1:0] divisor,
    output logic                      out_valid,
    output gtg_pkg::div_stage_t       out_stage
);
    import gtg_pkg::*;

    logic [IDX_W-1:0] valid_reg;
    div_stage_t       stage_reg [IDX_W];
    div_stage_t       stage_next [IDX_W];
    div_stage_t       src [IDX_W];
    div_trial_t       trial [IDX_W];

    // Stage k settles quotient bit IDX_W-1-k; the dividend shifts out at the
    // top as the quotient shifts in at the bottom.
    always_comb
    begin
        for (int k = 0; k < IDX_W; k++)
        begin
            if (k == 0)
            begin
                src[k].rem   = '0;
                src[k].dv    = in_idx;
                src[k].range = in_range;
            end
            else
            begin
                src[k] = stage_reg[k-1];
            end
            trial[k]            = div_trial(src[k].rem, src[k].dv[IDX_W-1], divisor);
            stage_next[k].rem   = trial[k].rem;
            stage_next[k].dv    = {src[k].dv[IDX_W-2:0], trial[k].ge};
            stage_next[k].range = src[k].range;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (adv)
        begin
            valid_reg <= {valid_reg[IDX_W-2:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int k = 0; k < IDX_W; k++)
            begin
                stage_reg[k] <= stage_next[k];
            end
        end
    end

    assign out_valid = valid_reg[IDX_W-1];
    assign out_stage = stage_reg[IDX_W-1];

endmodule
